### hw/rtl/sdes_pkg.sv
// ----------------------------------------------------------------------------
// sdes_pkg
// Shared types, constants and bit-level functions of the S-DES byte cipher.
// ----------------------------------------------------------------------------
package sdes_pkg;

  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;
  localparam int KEY_W   = 10;
  localparam int BYTE_W  = 8;
  localparam int HALF_W  = 4;

  // Register index, taken from the word address bit of paddr.
  localparam logic CFG_IDX_KEY = 1'b0;

  // Operation codes of an item.
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] k1;
    logic [BYTE_W-1:0] k2;
  } subkeys_t;

  typedef struct packed {
    logic              op;
    logic [HALF_W-1:0] left;
    logic [HALF_W-1:0] right;
  } stage_t;

  localparam logic [1:0] SBOX0 [0:3][0:3] = '{
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd2, 2'd1, 2'd3},
    '{2'd3, 2'd1, 2'd3, 2'd2}
  };

  localparam logic [1:0] SBOX1 [0:3][0:3] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd1, 2'd0},
    '{2'd2, 2'd1, 2'd0, 2'd3}
  };

  // Initial permutation; position 1 is the MSB.
  function automatic logic [7:0] perm_ip(logic [7:0] d);
    return {d[6], d[2], d[5], d[7], d[4], d[0], d[3], d[1]};
  endfunction

  // Inverse of the initial permutation.
  function automatic logic [7:0] perm_ipi(logic [7:0] t);
    return {t[4], t[7], t[5], t[3], t[1], t[6], t[0], t[2]};
  endfunction

  // Round function: E/P, subkey XOR, both S-boxes and P4.
  function automatic logic [3:0] round_f(logic [3:0] r, logic [7:0] k);
    logic [7:0] ep;
    logic [3:0] a;
    logic [3:0] b;
    logic [1:0] s0;
    logic [1:0] s1;
    logic [3:0] s;
    ep = {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]} ^ k;
    a  = ep[7:4];
    b  = ep[3:0];
    s0 = SBOX0[{a[3], a[0]}][{a[2], a[1]}];
    s1 = SBOX1[{b[3], b[0]}][{b[2], b[1]}];
    s  = {s0, s1};
    return {s[2], s[0], s[1], s[3]};
  endfunction

endpackage

### hw/rtl/sdes_key_sched.sv
// ----------------------------------------------------------------------------
// sdes_key_sched
// Derives the two round subkeys from the 10-bit key by P10, half rotations
// and P8.
// ----------------------------------------------------------------------------
module sdes_key_sched (
  input  logic [sdes_pkg::KEY_W-1:0] key,
  output sdes_pkg::subkeys_t         subkeys
);
  import sdes_pkg::*;

  logic [KEY_W-1:0] p10;
  logic [KEY_W-1:0] rot1;
  logic [KEY_W-1:0] rot3;

  // P10 with position 1 as the MSB.
  assign p10 = {key[7], key[5], key[8], key[3], key[6],
                key[0], key[9], key[1], key[2], key[4]};

  // Each five-bit half rotated left by one, then by a further two.
  assign rot1 = {p10[8:5], p10[9], p10[3:0], p10[4]};
  assign rot3 = {p10[6:5], p10[9:7], p10[1:0], p10[4:2]};

  // P8 picks eight of the ten rotated bits.
  assign subkeys.k1 = {rot1[4], rot1[7], rot1[3], rot1[6],
                       rot1[2], rot1[5], rot1[0], rot1[1]};
  assign subkeys.k2 = {rot3[4], rot3[7], rot3[3], rot3[6],
                       rot3[2], rot3[5], rot3[0], rot3[1]};

endmodule

### hw/rtl/sdes_round.sv
// ----------------------------------------------------------------------------
// sdes_round
// One registered Feistel round: left half XOR round function of the right
// half, with valid/ready flow control. The swap is left to the caller.
// ----------------------------------------------------------------------------
module sdes_round (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  sdes_pkg::stage_t                up_data,
  input  logic [sdes_pkg::BYTE_W-1:0]     subkey,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output sdes_pkg::stage_t                dn_data
);
  import sdes_pkg::*;

  logic   valid_r;
  stage_t data_r;
  stage_t data_nxt;

  always_comb begin
    data_nxt       = up_data;
    data_nxt.left  = up_data.left ^ round_f(up_data.right, subkey);
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

### hw/rtl/sdes_byte_cipher.sv
// ----------------------------------------------------------------------------
// sdes_byte_cipher
// Simplified DES on one byte per item, encrypting or decrypting under a
// 10-bit key held in a configuration register.
// ----------------------------------------------------------------------------
// Usage:
//   The key is written through the APB-style cfg_ port at byte address 0
//   and read back from the same place. It should be written only while no
//   item is in flight. The subkeys follow the key register directly, so an
//   item may be offered in the cycle after the write completes.
//   An item (in_operation, in_data_in) is accepted when in_valid and
//   in_ready are both high; in_operation low encrypts, high decrypts.
//   The result appears on out_data_out with out_valid once the item has
//   passed the initial permutation register and both round registers, and
//   a ready receiver then takes it. The pipeline has three register stages:
//   the initial permutation, round one, and round two, whose output passes
//   through the inverse permutation as plain wiring. One item is accepted in
//   every cycle in steady state while the receiver keeps out_ready high.
//   When the receiver holds out_ready low, the result stays on the port and
//   the stages behind it keep filling; in_ready drops only once all three
//   stages hold an item. A stall neither loses nor repeats an item.
//   Reset clears the key to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module sdes_byte_cipher (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [sdes_pkg::APB_AW-1:0]     cfg_paddr,
  input  logic [sdes_pkg::APB_DW-1:0]     cfg_pwdata,
  output logic [sdes_pkg::APB_DW-1:0]     cfg_prdata,
  output logic                            cfg_pready,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_operation,
  input  logic [sdes_pkg::BYTE_W-1:0]     in_data_in,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sdes_pkg::BYTE_W-1:0]     out_data_out
);
  import sdes_pkg::*;

  // Configuration register. The word address bit selects the register;
  // the byte offset bits are not decoded.
  logic [KEY_W-1:0] key_r;
  logic             key_sel;

  assign key_sel    = (cfg_paddr[2] == CFG_IDX_KEY);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && key_sel) begin
      key_r <= cfg_pwdata[KEY_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (key_sel) begin
      cfg_prdata = {{(APB_DW-KEY_W){1'b0}}, key_r};
    end
  end

  // Subkeys are pure rewiring of the key.
  subkeys_t subkeys;

  sdes_key_sched u_key_sched (
    .key     (key_r),
    .subkeys (subkeys)
  );

  // Stage A: initial permutation, split into halves.
  logic   a_valid_r;
  stage_t a_data_r;
  stage_t a_data_nxt;
  logic   b_up_ready;

  always_comb begin
    a_data_nxt.op                       = in_operation;
    {a_data_nxt.left, a_data_nxt.right} = perm_ip(in_data_in);
  end

  assign in_ready = !a_valid_r || b_up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_data_r <= a_data_nxt;
    end
  end

  // Stage B: first round. Encryption starts with K1, decryption with K2.
  logic [BYTE_W-1:0] b_subkey;
  logic              b_valid;
  stage_t            b_data;
  logic              c_up_ready;

  assign b_subkey = (a_data_r.op == OP_DECRYPT) ? subkeys.k2 : subkeys.k1;

  sdes_round u_round1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (a_valid_r),
    .up_ready (b_up_ready),
    .up_data  (a_data_r),
    .subkey   (b_subkey),
    .dn_valid (b_valid),
    .dn_ready (c_up_ready),
    .dn_data  (b_data)
  );

  // The halves swap between the rounds.
  stage_t            b_swapped;
  logic [BYTE_W-1:0] c_subkey;
  stage_t            c_data;

  always_comb begin
    b_swapped.op    = b_data.op;
    b_swapped.left  = b_data.right;
    b_swapped.right = b_data.left;
  end

  assign c_subkey = (b_data.op == OP_DECRYPT) ? subkeys.k1 : subkeys.k2;

  // Stage C: second round, no swap after it.
  sdes_round u_round2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (b_valid),
    .up_ready (c_up_ready),
    .up_data  (b_swapped),
    .subkey   (c_subkey),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (c_data)
  );

  // The inverse permutation is wiring on the output register.
  assign out_data_out = perm_ipi({c_data.left, c_data.right});

endmodule

### hw/rtl/sdes_chk.sv
// ----------------------------------------------------------------------------
// sdes_chk
// Port-level checks of the S-DES byte cipher, bound to the top level.
// ----------------------------------------------------------------------------
module sdes_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sdes_pkg::BYTE_W-1:0] out_data_out
);
  import sdes_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_out))
    else $error("sdes_chk: stalled result changed or vanished");

  // The pipeline comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("sdes_chk: result present straight after reset");

  // Input back-pressure only arises from a stalled receiver.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("sdes_chk: input refused without an output stall");

  // With no new item and a willing receiver, the pipeline drains empty.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_acc && out_ready) ##1 (!in_acc && out_ready) ##1 (!in_acc && out_ready)
    |=> !out_valid)
    else $error("sdes_chk: result appeared without a matching item");

endmodule

bind sdes_byte_cipher sdes_chk u_sdes_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_data_out (out_data_out)
);

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the S-DES byte cipher. A local model works out the
// ciphertext or plaintext of every accepted item from the key that the bench
// has written, and a monitor compares each result as it leaves the block.
// The run covers directed keys and bytes, a known test vector, a write to an
// unused register, random keys with random traffic, a long receiver hold and
// a closing stretch of back-to-back items.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sdes_pkg::*;

  // The key register lives at index 0; index 1 decodes to nothing and a
  // write there must leave the key alone.
  localparam logic CFG_IDX_SPARE = 1'b1;

  // Pipeline depth is three stages, so a handful of cycles covers the tail.
  localparam int TAIL_CYCLES = 8;
  localparam int HOLD_CYCLES = 40;

  // Permutation tables, one 4-bit source position per entry, first entry in
  // the top nibble. Positions are 1-based and counted from the MSB.
  localparam logic [39:0] P10_POS = {4'd3, 4'd5, 4'd2, 4'd7, 4'd4, 4'd10, 4'd1, 4'd9,
                                     4'd8, 4'd6};
  localparam logic [39:0] P8_POS  = {4'd6, 4'd3, 4'd7, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9, 8'd0};
  localparam logic [39:0] IP_POS  = {4'd2, 4'd6, 4'd3, 4'd1, 4'd4, 4'd8, 4'd5, 4'd7, 8'd0};
  localparam logic [39:0] IPI_POS = {4'd4, 4'd1, 4'd3, 4'd5, 4'd7, 4'd2, 4'd8, 4'd6, 8'd0};
  localparam logic [39:0] EP_POS  = {4'd4, 4'd1, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4, 4'd1, 8'd0};
  localparam logic [39:0] P4_POS  = {4'd2, 4'd4, 4'd3, 4'd1, 24'd0};

  // S-boxes flattened row by row, two bits per entry, entry 0 at the top.
  localparam logic [31:0] S0_TAB = {2'd1, 2'd0, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0,
                                    2'd0, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd3, 2'd2};
  localparam logic [31:0] S1_TAB = {2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3,
                                    2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3};

  typedef struct {
    logic              op;
    logic [BYTE_W-1:0] data;
    logic [KEY_W-1:0]  key;
    logic [BYTE_W-1:0] result;
  } cipher_job_t;

  // Every input is at a known level from time zero.
  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              cfg_psel     = 1'b0;
  logic              cfg_penable  = 1'b0;
  logic              cfg_pwrite   = 1'b0;
  logic [APB_AW-1:0] cfg_paddr    = '0;
  logic [APB_DW-1:0] cfg_pwdata   = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic              in_operation = OP_ENCRYPT;
  logic [BYTE_W-1:0] in_data_in   = '0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic [BYTE_W-1:0] out_data_out;

  // Key as the bench believes the block holds it, and the results still owed.
  logic [KEY_W-1:0]  key_shadow = '0;
  cipher_job_t       expected_bytes[$];

  // Idling controls: random gaps on the sender and stalls on the receiver.
  bit tx_idle_on   = 1'b0;
  bit rx_idle_on   = 1'b0;
  int hold_request = 0;
  int stall_left   = 0;

  int error_count   = 0;
  int items_sent    = 0;
  int decrypts_sent = 0;
  int results_seen  = 0;
  int keys_loaded   = 0;

  sdes_byte_cipher dut (.*);

  always #5ns clk = ~clk;

  // --------------------------------------------------------------------------
  // Local model of the cipher
  // --------------------------------------------------------------------------

  // Output bit i, MSB first, takes the input bit at table entry i.
  function automatic logic [9:0] permute(input logic [9:0] v, input int in_w,
                                         input logic [39:0] map, input int out_w);
    logic [9:0] r;
    int         pos;
    r = '0;
    for (int i = 0; i < out_w; i++) begin
      pos = map[39-4*i -: 4];
      r = {r[8:0], v[in_w-pos]};
    end
    return r;
  endfunction

  function automatic logic [4:0] rotl5(input logic [4:0] h, input int n);
    return (h << n) | (h >> (5 - n));
  endfunction

  // One round function: expand, mix in the subkey, two S-box lookups, P4.
  function automatic logic [3:0] feistel(input logic [3:0] half, input logic [7:0] subkey);
    logic [7:0] x;
    int         row0;
    int         col0;
    int         row1;
    int         col1;
    logic [1:0] s0;
    logic [1:0] s1;
    x    = 8'(permute({6'd0, half}, 4, EP_POS, 8)) ^ subkey;
    row0 = {x[7], x[4]};
    col0 = {x[6], x[5]};
    row1 = {x[3], x[0]};
    col1 = {x[2], x[1]};
    s0   = S0_TAB[31-2*(4*row0+col0) -: 2];
    s1   = S1_TAB[31-2*(4*row1+col1) -: 2];
    return 4'(permute({6'd0, s0, s1}, 4, P4_POS, 4));
  endfunction

  // Full byte transform under a given key; decryption swaps the subkeys.
  function automatic logic [7:0] sdes_crypt(input logic op, input logic [7:0] data,
                                            input logic [9:0] key);
    logic [9:0] k;
    logic [7:0] k1;
    logic [7:0] k2;
    logic [7:0] t;
    logic [3:0] l;
    logic [3:0] r;
    logic [3:0] nl;
    k  = permute(key, 10, P10_POS, 10);
    k  = {rotl5(k[9:5], 1), rotl5(k[4:0], 1)};
    k1 = 8'(permute(k, 10, P8_POS, 8));
    k  = {rotl5(k[9:5], 2), rotl5(k[4:0], 2)};
    k2 = 8'(permute(k, 10, P8_POS, 8));
    t  = 8'(permute({2'd0, data}, 8, IP_POS, 8));
    l  = t[7:4];
    r  = t[3:0];
    nl = l ^ feistel(r, (op == OP_DECRYPT) ? k2 : k1);
    l  = r;
    r  = nl;
    l  = l ^ feistel(r, (op == OP_DECRYPT) ? k1 : k2);
    return 8'(permute({2'd0, l, r}, 8, IPI_POS, 8));
  endfunction

  // --------------------------------------------------------------------------
  // Shared helpers
  // --------------------------------------------------------------------------

  // Only the first ten failures are printed in full; the rest are counted.
  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t ERROR: %s", $time, msg);
    end
  endtask

  // Offers one item, holding it until the block takes it, and records what
  // should come back. The valid is left high so that the next item can follow
  // in the very next cycle.
  task automatic send_byte(input logic op, input logic [BYTE_W-1:0] data);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_data_in   <= data;
    do @(posedge clk); while (!in_ready);
    expected_bytes.push_back('{op, data, key_shadow, sdes_crypt(op, data, key_shadow)});
    items_sent++;
    if (op == OP_DECRYPT) begin
      decrypts_sent++;
    end
  endtask

  // Stops offering items and waits until every result has come back, then
  // for TAIL_CYCLES more, so that the block is quiet before a register write.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then the access cycle until pready; the bus then idles
  // so that the next transfer never drives the bus twice in one step.
  task automatic apb_write(input logic idx, input logic [APB_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    // Bits above the key width are dropped; the spare index holds nothing.
    if (idx == CFG_IDX_KEY) begin
      key_shadow = data[KEY_W-1:0];
      keys_loaded++;
    end
    @(posedge clk);
  endtask

  // Reads the key back and compares it with what the bench expects.
  task automatic check_key_readback();
    logic [APB_DW-1:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {CFG_IDX_KEY, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== APB_DW'(key_shadow)) begin
      report_error($sformatf("key readback: expected %03h, got %08h", key_shadow, got));
    end
    @(posedge clk);
  endtask

  task automatic load_key(input logic [APB_DW-1:0] data);
    wait_idle();
    apb_write(CFG_IDX_KEY, data);
    check_key_readback();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: ready with random short stalls, or a long hold on request. The
  // hold is counted down here, independently of the sender.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_request != 0) begin
      out_ready    <= 1'b0;
      stall_left   = hold_request - 1;
      hold_request = 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: each accepted result against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    cipher_job_t job;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_bytes.size() == 0) begin
        report_error($sformatf("unexpected result %02h with nothing outstanding",
                               out_data_out));
      end else begin
        job = expected_bytes.pop_front();
        if (out_data_out !== job.result) begin
          report_error($sformatf("%s %02h under key %03h: expected %02h, got %02h",
                                 (job.op == OP_DECRYPT) ? "decrypt" : "encrypt",
                                 job.data, job.key, job.result, out_data_out));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // With the reset key of zero, both operations on the byte extremes and an encrypt of A5.
  task automatic test_reset_key();
    send_byte(OP_ENCRYPT, 8'h00);
    send_byte(OP_ENCRYPT, 8'hFF);
    send_byte(OP_DECRYPT, 8'h00);
    send_byte(OP_DECRYPT, 8'hFF);
    send_byte(OP_ENCRYPT, 8'hA5);
  endtask

  // All-ones key written with garbage in the upper bus bits, which the
  // register must drop, then back to zero the same way.
  task automatic test_key_extremes();
    load_key(32'hFFFF_FFFF);
    send_byte(OP_ENCRYPT, 8'h00);
    send_byte(OP_ENCRYPT, 8'hFF);
    send_byte(OP_DECRYPT, 8'h55);
    send_byte(OP_DECRYPT, 8'hAA);
    load_key(32'hFFFF_FC00);
    send_byte(OP_ENCRYPT, 8'h80);
    send_byte(OP_DECRYPT, 8'h01);
  endtask

  // The textbook example: key 1010000010 turns 10010111 into 00111000, and
  // the decrypt of that ciphertext should give the plaintext back.
  task automatic test_known_vector();
    load_key(32'h0000_0282);
    send_byte(OP_ENCRYPT, 8'h97);
    send_byte(OP_DECRYPT, 8'h38);
    send_byte(OP_ENCRYPT, 8'h01);
    send_byte(OP_DECRYPT, 8'hFE);
  endtask

  // A write to the unused index must not disturb the key.
  task automatic test_spare_register();
    wait_idle();
    apb_write(CFG_IDX_SPARE, 32'hFFFF_FFFF);
    check_key_readback();
    send_byte(OP_ENCRYPT, 8'h97);
    send_byte(OP_DECRYPT, 8'h7F);
    send_byte(OP_ENCRYPT, 8'hFE);
  endtask

  // Several random keys (random upper bus bits included), random traffic,
  // with idling on both sides.
  task automatic test_random_keys();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (4) begin
      load_key($urandom());
      repeat (100) begin
        send_byte(1'($urandom_range(0, 1)), 8'($urandom()));
      end
    end
  endtask

  // The receiver stops for a long stretch while the sender keeps offering,
  // so that every stage fills and the input is pushed back.
  task automatic test_backpressure();
    tx_idle_on   = 1'b0;
    rx_idle_on   = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (30) begin
      send_byte(1'($urandom_range(0, 1)), 8'($urandom()));
    end
  endtask

  // Closing stretch: fresh key, items back to back, receiver always ready.
  task automatic test_streaming();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    load_key($urandom());
    repeat (100) begin
      send_byte(1'($urandom_range(0, 1)), 8'($urandom()));
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_key();
    test_key_extremes();
    test_known_vector();
    test_spare_register();
    test_random_keys();
    test_backpressure();
    test_streaming();

    wait_idle();
    if (expected_bytes.size() != 0) begin
      report_error($sformatf("%0d results never arrived", expected_bytes.size()));
    end

    $display("Checked %0d results from %0d items (%0d of them decrypts) over %0d key loads.",
             results_seen, items_sent, decrypts_sent, keys_loaded);
    $display("Run included a %0d-cycle receiver hold and a write to the unused index.",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // The watchdog ends a run that hangs; a correct run finishes well within this limit.
  initial begin : watchdog
    #500us;
    $display("Timed out with %0d results outstanding.", expected_bytes.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
